// ===== rtl/dmc_pkg.sv =====
// Shared types and constants for the direct-mapped write-through cache.
// Command/status structs between controller and datapath, config codes, sizing helpers.
// No dependencies.
`default_nettype none

package dmc_pkg;

	localparam int LINES_DEF     = 256;
	localparam int MEM_WORDS_DEF = 16384;

	localparam int WORD_W   = 32;
	localparam int ADDR_W   = 16;
	localparam int WADDR_W  = 14;  // word address width
	localparam int TAG_W    = 12;  // address bits above the 16-byte line offset
	localparam int WOFF_W   = 2;   // word within a line
	localparam int IDXB_W   = 4;   // index_bits register width
	localparam int TAGE_W   = TAG_W + 1;  // tag RAM entry: {valid, tag}

	// config port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS = 1'd1;

	localparam logic             ENABLE_RST     = 1'b1;
	localparam logic [IDXB_W-1:0] INDEX_BITS_RST = 4'd8;

	// address width of a RAM, at least one bit
	function automatic int ram_aw(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// physical main memory depth: addresses never exceed the 14-bit word space
	function automatic int mem_depth(input int mem_words);
		return (mem_words < (1 << WADDR_W)) ? mem_words : (1 << WADDR_W);
	endfunction

	typedef struct packed {
		logic clear;     // reset sweep: zero main memory and tag RAM
		logic capture;   // latch the incoming transaction
		logic tag_rd;    // read tag RAM and word RAM at the item's line
		logic decide;    // latch hit, restart fill counter
		logic mem_wr;    // write-through to memory, word RAM on hit
		logic mem_rd;    // read memory at the wrapped word address
		logic fill_sel;  // wrap unit takes the fill word address
		logic fill_wr;   // store one fill word, tag on the last
		logic load_out;  // load the result register
	} dmc_cmd_t;

	typedef struct packed {
		logic mis;        // item address not word aligned
		logic wr;         // item is a write
		logic en;         // cache enabled
		logic hit;        // tag RAM output matches (valid during decide)
		logic fill_last;  // current fill word is the last of the line
		logic clr_last;   // last entry of the reset sweep
		logic out_free;   // result register can take a new result
	} dmc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/dmc_ram.sv =====
// Generic single-port RAM, registered read.
// No dependencies.
`default_nettype none

module dmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                      wdata,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dmc_wrap.sv =====
// Word address modulo MEM_WORDS, two stages: reciprocal multiply, then correction.
// Depends on dmc_pkg.
`default_nettype none

module dmc_wrap import dmc_pkg::*; #(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic [WADDR_W-1:0]                      x,
	output logic      [ram_aw(mem_depth(MEM_WORDS))-1:0] r
);

	localparam int MEM_AW = ram_aw(mem_depth(MEM_WORDS));
	localparam int MW_LOG = $clog2(MEM_WORDS);
	localparam int SHIFT  = WADDR_W + MW_LOG;
	localparam longint unsigned RECIP = (longint'(1) << SHIFT) / longint'(MEM_WORDS);
	localparam int RC_W   = WADDR_W + 1;
	localparam int P_W    = WADDR_W + RC_W;
	localparam int MUL_W  = WADDR_W + MW_LOG + 1;

	logic [P_W-1:0]     prod;
	logic [WADDR_W-1:0] x_s1;
	logic [WADDR_W-1:0] q_s1;
	logic [MUL_W-1:0]   qm;
	logic [MUL_W-1:0]   rem;
	logic [MUL_W-1:0]   rem_fix;
	logic [MEM_AW-1:0]  r_s2;

	// quotient estimate is exact or one low
	assign prod = P_W'(x) * P_W'(RECIP);

	always_ff @(posedge clk) begin
		x_s1 <= x;
		q_s1 <= WADDR_W'(prod >> SHIFT);
	end

	always_comb begin
		qm  = MUL_W'(q_s1) * MUL_W'(MEM_WORDS);
		rem = MUL_W'(x_s1) - qm;
		if (rem >= MUL_W'(MEM_WORDS)) begin
			rem_fix = rem - MUL_W'(MEM_WORDS);
		end else begin
			rem_fix = rem;
		end
	end

	always_ff @(posedge clk) begin
		r_s2 <= MEM_AW'(rem_fix);
	end

	assign r = r_s2;

endmodule

`default_nettype wire

// ===== rtl/dmc_ctrl.sv =====
// Cache controller FSM: reset sweep, lookup, write-through, line fill, result hand-off.
// Depends on dmc_pkg.
`default_nettype none

module dmc_ctrl import dmc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire dmc_sts_t sts,
	output dmc_cmd_t      cmd
);

	typedef enum logic [10:0] {
		ST_CLEAR   = 11'b000_0000_0001,
		ST_IDLE    = 11'b000_0000_0010,
		ST_LOOKUP  = 11'b000_0000_0100,
		ST_DECIDE  = 11'b000_0000_1000,
		ST_WRITE   = 11'b000_0001_0000,
		ST_MEMRD   = 11'b000_0010_0000,
		ST_FILL_A  = 11'b000_0100_0000,
		ST_FILL_B  = 11'b000_1000_0000,
		ST_FILL_RD = 11'b001_0000_0000,
		ST_FILL_WR = 11'b010_0000_0000,
		ST_RESP    = 11'b100_0000_0000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.tag_rd = 1'b1;
				state_d    = sts.mis ? ST_RESP : ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				if (sts.wr) begin
					state_d = ST_WRITE;
				end else if (!sts.en) begin
					state_d = ST_MEMRD;
				end else if (sts.hit) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_FILL_A;
				end
			end
			ST_WRITE: begin
				cmd.mem_wr = 1'b1;
				state_d    = ST_RESP;
			end
			ST_MEMRD: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_RESP;
			end
			ST_FILL_A: begin
				cmd.fill_sel = 1'b1;
				state_d      = ST_FILL_B;
			end
			ST_FILL_B: begin
				cmd.fill_sel = 1'b1;
				state_d      = ST_FILL_RD;
			end
			ST_FILL_RD: begin
				cmd.fill_sel = 1'b1;
				cmd.mem_rd   = 1'b1;
				state_d      = ST_FILL_WR;
			end
			ST_FILL_WR: begin
				cmd.fill_wr = 1'b1;
				state_d     = sts.fill_last ? ST_RESP : ST_FILL_A;
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dmc_datapath.sv =====
// Cache datapath: config registers, item register, tag/word/main RAMs, address wrap,
// reset sweep counter and the result register.
// Depends on dmc_pkg, dmc_ram, dmc_wrap.
`default_nettype none

module dmc_datapath import dmc_pkg::*; #(
	parameter int LINES     = LINES_DEF,
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dmc_cmd_t               cmd,
	output dmc_sts_t                    sts,
	input  wire logic [ADDR_W+WORD_W-1:0] s_tdata,
	input  wire logic                   s_tuser,
	input  wire logic                   cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [WORD_W-1:0]           m_tdata,
	output logic [1:0]                  m_tuser
);

	localparam int LOG_LINES = $clog2(LINES);
	localparam int IDX_W     = ram_aw(LINES);
	localparam int WRAM_D    = LINES * 4;
	localparam int WRAM_AW   = ram_aw(WRAM_D);
	localparam int MEM_D     = mem_depth(MEM_WORDS);
	localparam int MEM_AW    = ram_aw(MEM_D);
	localparam int CLR_N     = (MEM_D > LINES) ? MEM_D : LINES;
	localparam int CLR_W     = ram_aw(CLR_N);
	localparam logic [IDXB_W-1:0] LOG_LINES_C = IDXB_W'(LOG_LINES);

	// config
	logic              en_q;
	logic [IDXB_W-1:0] index_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q         <= ENABLE_RST;
			index_bits_q <= INDEX_BITS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ENABLE:     en_q         <= cfg_data[0];
				CFG_INDEX_BITS: index_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item register
	logic              mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic [WORD_W-1:0] wdata_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= s_tuser;
			addr_q  <= s_tdata[ADDR_W-1:0];
			wdata_q <= s_tdata[ADDR_W+WORD_W-1:ADDR_W];
		end
	end

	// address split with the effective index width
	logic [IDXB_W-1:0] k_eff;
	logic [TAG_W-1:0]  line_addr;
	logic [TAG_W-1:0]  idx_full;
	logic [TAG_W-1:0]  tag;
	logic [IDX_W-1:0]  idx;
	logic [WOFF_W-1:0] woff;

	assign k_eff     = (index_bits_q > LOG_LINES_C) ? LOG_LINES_C : index_bits_q;
	assign line_addr = addr_q[ADDR_W-1:4];
	assign idx_full  = line_addr & ~({TAG_W{1'b1}} << k_eff);
	assign tag       = line_addr >> k_eff;
	assign idx       = idx_full[IDX_W-1:0];
	assign woff      = addr_q[3:2];

	// fill word counter and hit
	logic [WOFF_W-1:0] fa_q;
	logic              hit_q;
	logic              hit;
	logic [TAGE_W-1:0] tag_rdata;

	assign hit = en_q & tag_rdata[TAG_W] & (tag_rdata[TAG_W-1:0] == tag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fa_q  <= '0;
			hit_q <= 1'b0;
		end else if (cmd.decide) begin
			fa_q  <= '0;
			hit_q <= hit;
		end else if (cmd.fill_wr) begin
			fa_q <= fa_q + 1'b1;
		end
	end

	// reset sweep
	logic [CLR_W-1:0] clr_q;
	logic             clr_mem;
	logic             clr_tag;

	assign clr_mem = cmd.clear & ({1'b0, clr_q} < (CLR_W+1)'(MEM_D));
	assign clr_tag = cmd.clear & ({1'b0, clr_q} < (CLR_W+1)'(LINES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// word address wrap
	logic [WADDR_W-1:0] wrap_x;
	logic [MEM_AW-1:0]  mem_idx;

	assign wrap_x = cmd.fill_sel ? {line_addr, fa_q} : addr_q[ADDR_W-1:2];

	dmc_wrap #(
		.MEM_WORDS (MEM_WORDS)
	) u_wrap (
		.clk (clk),
		.x   (wrap_x),
		.r   (mem_idx)
	);

	// main memory
	logic [MEM_AW-1:0] mem_addr;
	logic [WORD_W-1:0] mem_rdata;

	assign mem_addr = cmd.clear ? clr_q[MEM_AW-1:0] : mem_idx;

	dmc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MEM_D)
	) u_mem (
		.clk   (clk),
		.we    (clr_mem | cmd.mem_wr),
		.re    (cmd.mem_rd),
		.addr  (mem_addr),
		.wdata (cmd.clear ? '0 : wdata_q),
		.rdata (mem_rdata)
	);

	// tag RAM: {valid, tag}
	logic [IDX_W-1:0] tag_addr;

	assign tag_addr = cmd.clear ? clr_q[IDX_W-1:0] : idx;

	dmc_ram #(
		.WIDTH (TAGE_W),
		.DEPTH (LINES)
	) u_tag (
		.clk   (clk),
		.we    (clr_tag | (cmd.fill_wr & (fa_q == '1))),
		.re    (cmd.tag_rd),
		.addr  (tag_addr),
		.wdata (cmd.clear ? '0 : {1'b1, tag}),
		.rdata (tag_rdata)
	);

	// line data RAM
	logic [WRAM_AW-1:0] word_addr;
	logic [WORD_W-1:0]  word_rdata;

	assign word_addr = cmd.fill_wr ? WRAM_AW'({idx, fa_q}) : WRAM_AW'({idx, woff});

	dmc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WRAM_D)
	) u_words (
		.clk   (clk),
		.we    ((cmd.mem_wr & hit_q) | cmd.fill_wr),
		.re    (cmd.tag_rd),
		.addr  (word_addr),
		.wdata (cmd.fill_wr ? mem_rdata : wdata_q),
		.rdata (word_rdata)
	);

	// requested word as it passes during the fill
	logic [WORD_W-1:0] fill_word_q;

	always_ff @(posedge clk) begin
		if (cmd.fill_wr && (fa_q == woff)) begin
			fill_word_q <= mem_rdata;
		end
	end

	// result register
	logic              mis;
	logic              m_tvalid_q;
	logic [WORD_W-1:0] rd_q;
	logic              hit_out_q;
	logic              mis_out_q;
	logic [WORD_W-1:0] rd_sel;

	assign mis = (addr_q[1:0] != 2'b00);

	always_comb begin
		if (mis || mode_q) begin
			rd_sel = '0;
		end else if (!en_q) begin
			rd_sel = mem_rdata;
		end else if (hit_q) begin
			rd_sel = word_rdata;
		end else begin
			rd_sel = fill_word_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rd_q      <= rd_sel;
			hit_out_q <= hit_q & ~mis;
			mis_out_q <= mis;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = rd_q;
	assign m_tuser  = {mis_out_q, hit_out_q};

	assign sts.mis       = mis;
	assign sts.wr        = mode_q;
	assign sts.en        = en_q;
	assign sts.hit       = hit;
	assign sts.fill_last = (fa_q == '1);
	assign sts.clr_last  = (clr_q == CLR_W'(CLR_N - 1));
	assign sts.out_free  = ~m_tvalid_q | m_tready;

endmodule

`default_nettype wire

// ===== rtl/direct_mapped_write_through_cache.sv =====
// Direct-mapped write-through, no-write-allocate cache with 16-byte lines in front of main memory.
// Per transaction: tag lookup; for an aligned address, a decide step, then a write-through, an
// uncached memory read, a read hit, or a read miss that fills four line words, each through the
// 2-stage address wrap and one main memory read. A new transaction is taken once the previous
// result is registered. After reset the block clears main memory and the tag RAM, one entry per
// cycle, max(min(MEM_WORDS,16384), LINES) entries, with s_tready low; config writes taken throughout.
// Depends on dmc_pkg, dmc_ctrl, dmc_datapath.
`default_nettype none

module direct_mapped_write_through_cache import dmc_pkg::*; #(
	parameter int LINES     = LINES_DEF,      // power of two, 1..4096
	parameter int MEM_WORDS = MEM_WORDS_DEF   // 16..1048576
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	// request stream
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [ADDR_W+WORD_W-1:0] s_tdata,   // [15:0] address, [47:16] wr_word
	input  wire logic                     s_tuser,   // [0] mode (1 = write)

	// result stream
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [WORD_W-1:0]             m_tdata,   // [31:0] read_data
	output logic [1:0]                    m_tuser,   // [0] hit, [1] misaligned

	// configuration writes
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index, // 0 cache_enable, 1 index_bits
	input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

	dmc_cmd_t cmd;
	dmc_sts_t sts;

	// config registers are plain flops, always writable
	assign cfg_ready = 1'b1;

	// sequencer: one transaction at a time
	dmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// RAMs, address split, wrap unit and result register
	dmc_datapath #(
		.LINES     (LINES),
		.MEM_WORDS (MEM_WORDS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

// ===== dv/tb_direct_mapped_write_through_cache.sv =====
// Testbench for the direct-mapped write-through cache.
// Shadow copy of memory and cache predicts every result; self-checking, no files read.
// Depends on dmc_pkg and the direct_mapped_write_through_cache RTL.
`timescale 1ns / 100ps

module tb_direct_mapped_write_through_cache import dmc_pkg::*; ();

	// sizes of the instance below (package defaults)
	localparam int NLINES = LINES_DEF;
	localparam int MAX_K  = $clog2(LINES_DEF);
	localparam int NWORDS = MEM_WORDS_DEF;

	// register settings walked by the random phases, extremes included
	localparam int NPHASES = 8;
	localparam int PHASE_ITEMS = 250;
	localparam bit PHASE_ENABLE [NPHASES] =
		'{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
	localparam bit [IDXB_W-1:0] PHASE_INDEX_BITS [NPHASES] =
		'{4'd8, 4'd0, 4'd8, 4'd15, 4'd2, 4'd5, 4'd0, 4'd4};

	typedef enum logic {
		ACC_READ  = 1'b0,
		ACC_WRITE = 1'b1
	} access_kind_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic              hit;
		logic              misaligned;
	} access_result_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	// block inputs, all known from time zero
	logic                     s_tvalid  = 1'b0;
	logic [ADDR_W+WORD_W-1:0] s_tdata   = '0;    // [15:0] address, [47:16] wr_word
	logic                     s_tuser   = 1'b0;  // [0] mode
	logic                     m_tready  = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = CFG_ENABLE;
	logic [CFG_DATA_W-1:0]    cfg_data  = '0;

	// block outputs
	logic              s_tready;
	logic              m_tvalid;
	logic [WORD_W-1:0] m_tdata;   // [31:0] read_data
	logic [1:0]        m_tuser;   // [0] hit, [1] misaligned
	logic              cfg_ready;

	direct_mapped_write_through_cache u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Shadow state: main memory, the line store and the two registers.
	// 2-state arrays start at zero, same as the block after its clear.
	// ------------------------------------------------------------------
	bit              shadow_valid [NLINES];
	bit [TAG_W-1:0]  shadow_tag   [NLINES];
	bit [WORD_W-1:0] shadow_words [NLINES*4];
	bit [WORD_W-1:0] shadow_mem   [NWORDS];
	bit              cur_enable     = ENABLE_RST;
	bit [IDXB_W-1:0] cur_index_bits = INDEX_BITS_RST;

	access_result_t access_results_due[$];

	// flow control knobs shared with the sink process
	bit src_steady  = 1'b0;  // sender never idles
	bit sink_steady = 1'b0;  // receiver never stalls
	int hold_len    = 0;     // length of a long receiver hold-off
	int hold_seq    = 0;     // bumped to start one

	// bookkeeping
	int mismatches = 0;
	int n_reads = 0, n_writes = 0, n_hits = 0, n_misaligned = 0;
	int n_cfg_writes = 0, n_settings = 0;

	// lines in use, saturated to what the cache holds
	function automatic int eff_k();
		return (int'(cur_index_bits) > MAX_K) ? MAX_K : int'(cur_index_bits);
	endfunction

	// One access applied to the shadow state; returns the result the block owes.
	function automatic access_result_t cached_access(input access_kind_t kind,
			input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] wdata);
		access_result_t  res;
		int              k, idx, woff;
		logic [TAG_W-1:0]   tag;
		logic [WADDR_W-1:0] waddr, base;
		res = '0;
		// misaligned: flagged, nothing touched
		if (addr[1:0] != 2'b00) begin
			res.misaligned = 1'b1;
			return res;
		end
		waddr = addr[ADDR_W-1:2];
		if (!cur_enable) begin
			// cache bypassed: never a hit, lines left alone
			if (kind == ACC_WRITE)
				shadow_mem[waddr] = wdata;
			else
				res.read_data = shadow_mem[waddr];
			return res;
		end
		k    = eff_k();
		idx  = (int'(addr) >> 4) & ((1 << k) - 1);
		tag  = TAG_W'(int'(addr) >> (4 + k));
		woff = int'(addr[3:2]);
		res.hit = shadow_valid[idx] && (shadow_tag[idx] == tag);
		if (kind == ACC_WRITE) begin
			// write-through; no allocation on a miss
			if (res.hit)
				shadow_words[idx*4 + woff] = wdata;
			shadow_mem[waddr] = wdata;
		end else if (res.hit) begin
			res.read_data = shadow_words[idx*4 + woff];
		end else begin
			// read miss: whole line from memory
			base = {addr[ADDR_W-1:4], 2'b00};
			shadow_valid[idx] = 1'b1;
			shadow_tag[idx]   = tag;
			for (int a = 0; a < 4; a++)
				shadow_words[idx*4 + a] = shadow_mem[base + WADDR_W'(a)];
			res.read_data = shadow_mem[waddr];
		end
		return res;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// ------------------------------------------------------------------
	// Sender. Starts and ends at a falling edge; tvalid is left high so the
	// next transaction can follow without a bubble. Whoever stops sending
	// lowers it (see wait_drain).
	// ------------------------------------------------------------------
	task automatic send_access(input access_kind_t kind, input logic [ADDR_W-1:0] addr,
			input logic [WORD_W-1:0] wdata);
		int gap;
		access_result_t res;
		gap = src_steady ? 0 : idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {wdata, addr};
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		res = cached_access(kind, addr, wdata);
		access_results_due.push_back(res);
		if (kind == ACC_WRITE) n_writes++; else n_reads++;
		if (res.hit) n_hits++;
		if (res.misaligned) n_misaligned++;
		@(negedge clk);
	endtask

	// stop offering and wait until every owed result has come back
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (access_results_due.size() != 0) @(negedge clk);
	endtask

	// Both registers in one go, only with the block idle. Every result is
	// owed per transaction, so an empty queue means nothing is in flight.
	task automatic write_cfg(input bit en, input logic [IDXB_W-1:0] ib);
		logic [CFG_DATA_W-1:0] word;
		wait_drain();
		word = CFG_DATA_W'($urandom);  // upper bits are don't-care for the enable
		word[0] = en;
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ENABLE;
		cfg_data  <= word;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cur_enable = en;
		@(negedge clk);
		cfg_index <= CFG_INDEX_BITS;
		cfg_data  <= ib;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cur_index_bits = ib;
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_cfg_writes += 2;
		n_settings++;
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls, a steady mode, and a long hold-off counted
	// here in cycles whenever hold_seq moves.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int stall, seen_seq, hold;
		stall = 0;
		seen_seq = 0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold_seq != seen_seq) begin
				seen_seq = hold_seq;
				hold = hold_len;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (sink_steady) begin
				m_tready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 99) < 35) stall = idle_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// Result check: each accepted result against the oldest one owed.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		access_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.read_data  = m_tdata;
			got.hit        = m_tuser[0];
			got.misaligned = m_tuser[1];
			if (access_results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result with none owed: data=%08h hit=%0b mis=%0b",
						$time, got.read_data, got.hit, got.misaligned);
			end else begin
				want = access_results_due.pop_front();
				if (got.read_data !== want.read_data || got.hit !== want.hit ||
						got.misaligned !== want.misaligned) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] mismatch: want data=%08h hit=%0b mis=%0b,",
							$time, want.read_data, want.hit, want.misaligned,
							" got data=%08h hit=%0b mis=%0b",
							got.read_data, got.hit, got.misaligned);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset settings (cache on, 256 lines): hits, fills, write-through,
	// write miss without allocation, eviction, misaligned addresses
	task automatic test_directed_corners();
		send_access(ACC_READ,  16'h0000, 32'h0);           // miss, zero fill
		send_access(ACC_READ,  16'h0004, 32'hFFFF_FFFF);   // hit, data ignored
		send_access(ACC_WRITE, 16'h0008, 32'hDEAD_BEEF);   // write hit
		send_access(ACC_READ,  16'h0008, 32'h0);
		send_access(ACC_WRITE, 16'hFFFC, 32'hFFFF_FFFF);   // write miss, memory only
		send_access(ACC_READ,  16'hFFFC, 32'h0);           // fill top line
		send_access(ACC_WRITE, 16'hFFFC, 32'h0000_0000);
		send_access(ACC_READ,  16'hFFFC, 32'h0);
		send_access(ACC_READ,  16'hFFF0, 32'h0);
		send_access(ACC_WRITE, 16'h1000, 32'h1234_5678);   // same line, other tag
		send_access(ACC_READ,  16'h0008, 32'h0);           // old tag still there
		send_access(ACC_READ,  16'h1000, 32'h0);           // evicts tag 0
		send_access(ACC_READ,  16'h0008, 32'h0);           // refill from memory
		send_access(ACC_READ,  16'h0001, 32'h0);           // misaligned
		send_access(ACC_WRITE, 16'h0002, 32'hFFFF_FFFF);
		send_access(ACC_WRITE, 16'hFFFF, 32'hA5A5_A5A5);
		send_access(ACC_READ,  16'h0000, 32'h0);           // untouched by the above
		wait_drain();
	endtask

	// writes with the cache off reach memory only; lines come back stale
	task automatic test_uncached_writes_leave_lines_stale();
		write_cfg(1'b1, 4'd8);
		send_access(ACC_READ,  16'h2040, 32'h0);
		write_cfg(1'b0, 4'd8);
		send_access(ACC_WRITE, 16'h2040, 32'hCAFE_F00D);
		send_access(ACC_READ,  16'h2040, 32'h0);           // straight from memory
		write_cfg(1'b1, 4'd8);
		send_access(ACC_READ,  16'h2040, 32'h0);           // stale hit
		send_access(ACC_WRITE, 16'h2040, 32'h0BAD_CAFE);
		send_access(ACC_READ,  16'h2040, 32'h0);
		wait_drain();
	endtask

	// index widths from a single line up to past saturation, two aliasing lines
	task automatic test_index_width_extremes();
		logic [IDXB_W-1:0] widths [4];
		logic [ADDR_W-1:0] a0, a1;
		widths = '{4'd0, 4'd15, 4'd1, 4'd7};
		foreach (widths[w]) begin
			write_cfg(1'b1, widths[w]);
			a0 = 16'h0300;
			a1 = a0 + (ADDR_W'(16) << eff_k());
			for (int j = 0; j < 12; j++)
				send_access((j % 3 == 2) ? ACC_WRITE : ACC_READ,
					((j % 2) ? a1 : a0) + ADDR_W'(((j / 2) % 4) * 4), $urandom);
		end
		wait_drain();
	endtask

	// receiver holds off for a long stretch while items keep coming
	task automatic test_result_backpressure();
		write_cfg(1'b1, 4'd8);
		src_steady = 1'b1;
		hold_len = 400;
		hold_seq++;
		for (int j = 0; j < 24; j++)
			send_access(($urandom_range(0, 2) == 0) ? ACC_WRITE : ACC_READ,
				16'h4400 + ADDR_W'($urandom_range(0, 31) * 4), $urandom);
		src_steady = 1'b0;
		wait_drain();
	endtask

	// Phases over the register settings; hot lines plus aliases of them so
	// that hits, fills, evictions and write hits all happen often.
	task automatic test_random_traffic();
		logic [ADDR_W-1:0] bases [6];
		logic [ADDR_W-1:0] addr;
		int r;
		access_kind_t kind;
		for (int p = 0; p < NPHASES; p++) begin
			write_cfg(PHASE_ENABLE[p], PHASE_INDEX_BITS[p]);
			src_steady  = (p == 3) || ($urandom_range(0, 3) == 0);
			sink_steady = (p == 3) || ($urandom_range(0, 3) == 0);
			for (int b = 0; b < 4; b++)
				bases[b] = ADDR_W'($urandom) & 16'hFFF0;
			bases[4] = bases[0] + (ADDR_W'(16) << eff_k());
			bases[5] = bases[1] + (ADDR_W'(32) << eff_k());
			for (int j = 0; j < PHASE_ITEMS; j++) begin
				// sender pause mid-phase until everything has come back
				if (j == PHASE_ITEMS / 2 && (p % 2) == 0)
					wait_drain();
				r = $urandom_range(0, 99);
				if (r < 75)
					addr = bases[$urandom_range(0, 5)] + ADDR_W'($urandom_range(0, 15) * 4);
				else if (r < 90)
					addr = ADDR_W'($urandom) & 16'hFFFC;
				else
					addr = {WADDR_W'($urandom), 2'($urandom_range(1, 3))};
				kind = ($urandom_range(0, 99) < 60) ? ACC_READ : ACC_WRITE;
				send_access(kind, addr, $urandom);
			end
		end
		src_steady  = 1'b0;
		sink_steady = 1'b0;
		wait_drain();
	endtask

	// ------------------------------------------------------------------
	// Sequence. The first transaction waits out the post-reset clear on
	// s_tready by itself.
	// ------------------------------------------------------------------
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_corners();
		test_uncached_writes_leave_lines_stale();
		test_index_width_extremes();
		test_result_backpressure();
		test_random_traffic();

		wait_drain();
		// a few result latencies for anything spurious to show up
		repeat (40) @(negedge clk);

		$display("covered %0d accesses: %0d reads, %0d writes, %0d hits, %0d misaligned",
			n_reads + n_writes, n_reads, n_writes, n_hits, n_misaligned);
		$display("%0d register writes over %0d settings, cache off and index widths 0..15",
			n_cfg_writes, n_settings);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog: well beyond the slowest legal run, clear pass included
	initial begin
		#50_000_000;
		$display("timeout with %0d results outstanding", access_results_due.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
